// File: sv/sha_pkg.sv
// Package: SHA-256 constants, types and a rotate function.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // front-to-back queue entry: one 32-bit big-endian message word
   typedef struct packed {
      logic [31:0] word;
      logic        block_end;   // word 15 of a block
      logic        msg_end;     // length word of a message's last block
   } word_type;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = 2;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] StartHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: sv/sha_if.sv
// Valid/ready channel interfaces.
interface sha_req_if;
   logic               valid;
   logic               ready;
   sha_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sha_rsp_if;
   logic               valid;
   logic               ready;
   sha_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/sha_front.sv
// Front end: packs bytes into words, inserts padding and length.
module sha_front (
   input  logic               clock,
   input  logic               reset,
   sha_req_if.sink            req,
   output logic               wq_valid,
   output sha_pkg::word_type  wq_data,
   input  logic               wq_ready
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_DATA = 3'b001,
      ST_PAD  = 3'b010,
      ST_LEN  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;       // byte position in block
   logic [63:0] bits_ff, bits_in;
   logic [23:0] part_ff, part_in;       // bytes of the current word so far
   logic        pad_byte_ff, pad_byte_in; // pad byte still pending in ST_PAD
   logic        len_hi_ff, len_hi_in;   // which length word is next

   logic [31:0] word;
   logic        emit;
   logic [7:0]  cur_byte;
   logic        take_byte;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      bits_in     = bits_ff;
      part_in     = part_ff;
      pad_byte_in = pad_byte_ff;
      len_hi_in   = len_hi_ff;
      req.ready   = 1'b0;
      emit        = 1'b0;
      word        = '0;
      wq_data     = '0;
      cur_byte    = '0;
      take_byte   = 1'b0;
      case (state_ff)
         ST_DATA: begin
            // a byte that completes a word needs queue space
            req.ready = wq_ready || (fill_ff[1:0] != 2'd3);
            if (req.valid && req.ready) begin
               if (req.payload.byte_present) begin
                  take_byte = 1'b1;
                  cur_byte  = req.payload.data_byte;
                  bits_in   = bits_ff + 64'd8;
               end
               if (req.payload.end_of_message) begin
                  state_in    = ST_PAD;
                  pad_byte_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            if (wq_ready) begin
               take_byte   = 1'b1;
               cur_byte    = pad_byte_ff ? PadByte : 8'h00;
               pad_byte_in = 1'b0;
            end
         end
         ST_LEN: begin
            if (wq_ready) begin
               emit = 1'b1;
               word = len_hi_ff ? bits_ff[63:32] : bits_ff[31:0];
               wq_data.block_end = !len_hi_ff;
               wq_data.msg_end   = 1'b1;
               len_hi_in = !len_hi_ff;
               fill_in   = fill_ff + 6'd4;
               if (!len_hi_ff) begin
                  state_in = ST_DATA;
                  bits_in  = '0;
               end
            end
         end
         default: state_in = ST_DATA;
      endcase

      if (take_byte) begin
         case (fill_ff[1:0])
            2'd0: part_in[23:16] = cur_byte;
            2'd1: part_in[15:8]  = cur_byte;
            2'd2: part_in[7:0]   = cur_byte;
            default: begin
               emit = 1'b1;
               word = {part_ff, cur_byte};
               wq_data.block_end = (fill_ff == 6'd63);
            end
         endcase
         fill_in = fill_ff + 6'd1;
         // padding reached the length slots of the block
         if (state_ff == ST_PAD && fill_in == LenOffset) begin
            state_in  = ST_LEN;
            len_hi_in = 1'b1;
         end
      end
      wq_data.word = word;
      wq_valid     = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DATA;
         fill_ff     <= '0;
         bits_ff     <= '0;
         pad_byte_ff <= 1'b0;
         len_hi_ff   <= 1'b1;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         pad_byte_ff <= pad_byte_in;
         len_hi_ff   <= len_hi_in;
      end
      part_ff <= part_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEN |-> fill_ff[5:3] == 3'b111)
      else $error("length words outside last block slots");
   assert property (@(posedge clock) disable iff (reset)
      wq_valid && wq_data.block_end |-> fill_ff == 6'd63 || state_ff == ST_LEN)
      else $error("block end at wrong position");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD |-> !req.ready)
      else $error("input taken during padding");
endmodule

// File: sv/sha_queue.sv
// Small FIFO between the front end and the compression engine.
module sha_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sha_pkg::word_type  in_data,
   output logic               in_ready,
   output logic               out_valid,
   output sha_pkg::word_type  out_data,
   input  logic               out_ready
);
   import sha_pkg::*;

   word_type           mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, rd_ff;
   logic [QueueAw:0]   cnt_ff;
   logic               push, pop;

   assign in_ready  = cnt_ff != (QueueAw+1)'(QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QueueAw+1)'(QueueDepth))
      else $error("queue overflow");
endmodule

// File: sv/sha_back.sv
// Compression engine: 16-word window, one round per cycle (rounds 0-15 only as words arrive), digest output.
module sha_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               wq_valid,
   input  sha_pkg::word_type  wq_data,
   output logic               wq_ready,
   sha_rsp_if.source          rsp
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  round_ff;
   logic [3:0]  load_ff;
   logic        msg_ff;
   logic [2:0]  out_ff;

   logic [31:0] w_cur, s0w, s1w, w_new, t1, t2, e, a;
   logic        loading, step;

   assign loading  = state_ff == ST_LOAD && wq_valid;
   assign wq_ready = state_ff == ST_LOAD;
   assign step     = loading || state_ff == ST_RUN;

   // rounds 0..15 run while words arrive; schedule extension afterwards
   always_comb begin
      s0w   = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w   = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0w + w_ff[9] + s1w;
      w_cur = loading ? wq_data.word : w_new;
      a = v_ff[0];
      e = v_ff[4];
      t1 = v_ff[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + RoundK[round_ff] + w_cur;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (loading && load_ff == 4'd15) state_in = ST_RUN;
         ST_RUN:  if (round_ff == 6'd63) state_in = msg_ff ? ST_OUT : ST_LOAD;
         ST_OUT:  if (rsp.ready && out_ff == 3'd7) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp.valid               = state_ff == ST_OUT;
   assign rsp.payload.digest_word = h_ff[out_ff];
   assign rsp.payload.word_index  = out_ff;
   assign rsp.payload.last_word   = out_ff == 3'd7;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         round_ff <= '0;
         load_ff  <= '0;
         out_ff   <= '0;
         msg_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= StartHash[i];
            v_ff[i] <= StartHash[i];
         end
      end else begin
         state_ff <= state_in;
         if (loading) begin
            load_ff <= load_ff + 4'd1;
            if (load_ff == 4'd15) msg_ff <= wq_data.msg_end;
         end
         if (step) round_ff <= round_ff + 6'd1;
         if (state_ff == ST_RUN && round_ff == 6'd63) begin
            // fold the final round straight into the hash
            h_ff[0] <= h_ff[0] + t1 + t2;
            h_ff[1] <= h_ff[1] + v_ff[0];
            h_ff[2] <= h_ff[2] + v_ff[1];
            h_ff[3] <= h_ff[3] + v_ff[2];
            h_ff[4] <= h_ff[4] + v_ff[3] + t1;
            h_ff[5] <= h_ff[5] + v_ff[4];
            h_ff[6] <= h_ff[6] + v_ff[5];
            h_ff[7] <= h_ff[7] + v_ff[6];
            v_ff[0] <= h_ff[0] + t1 + t2;
            v_ff[1] <= h_ff[1] + v_ff[0];
            v_ff[2] <= h_ff[2] + v_ff[1];
            v_ff[3] <= h_ff[3] + v_ff[2];
            v_ff[4] <= h_ff[4] + v_ff[3] + t1;
            v_ff[5] <= h_ff[5] + v_ff[4];
            v_ff[6] <= h_ff[6] + v_ff[5];
            v_ff[7] <= h_ff[7] + v_ff[6];
         end else if (step) begin
            v_ff[0] <= t1 + t2;
            v_ff[1] <= v_ff[0];
            v_ff[2] <= v_ff[1];
            v_ff[3] <= v_ff[2];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[5] <= v_ff[4];
            v_ff[6] <= v_ff[5];
            v_ff[7] <= v_ff[6];
         end
         if (state_ff == ST_OUT && rsp.ready) begin
            out_ff <= out_ff + 3'd1;
            if (out_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= StartHash[i];
                  v_ff[i] <= StartHash[i];
               end
            end
         end
      end
      if (step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> round_ff[5:4] == 2'b00 && round_ff[3:0] == load_ff)
      else $error("round count out of step with load count");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> round_ff >= 6'd16)
      else $error("schedule extension before block loaded");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(out_ff))
      else $error("digest index moved while stalled");
   assert property (@(posedge clock) disable iff (reset)
      loading |-> wq_data.block_end == (load_ff == 4'd15))
      else $error("block end marker out of step with word count");
endmodule

// File: sv/sha256_stream_hash_unit.sv
// SHA-256 byte-stream hasher: one byte per item, digest as eight 32-bit words.
// Input bytes are taken at one per cycle while the four-word queue has room;
// the compression engine runs rounds 0-15 as words arrive and rounds 16-63
// afterwards, taking no words meanwhile. During rounds 16-63 the queue and
// the partial word absorb up to 19 bytes and input then stalls. An end-of-message
// item is followed by padding generated at one byte per cycle while the
// queue has room (up to two blocks, no input taken meanwhile), and the
// digest is then sent as eight items, word 0 first.
module sha256_stream_hash_unit (
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   import sha_pkg::*;

   logic     f_valid, f_ready, b_valid, b_ready;
   word_type f_data, b_data;

   sha_front u_front (
      .clock, .reset, .req,
      .wq_valid(f_valid), .wq_data(f_data), .wq_ready(f_ready)
   );

   sha_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
      .out_valid(b_valid), .out_data(b_data), .out_ready(b_ready)
   );

   sha_back u_back (
      .clock, .reset,
      .wq_valid(b_valid), .wq_data(b_data), .wq_ready(b_ready), .rsp
   );
endmodule

// File: dv/sha256_stream_hash_unit_test.sv
// Testbench for the SHA-256 byte-stream hasher: random messages checked against a digest predictor.
`timescale 1ns / 100ps

module sha256_stream_hash_unit_test;
   import sha_pkg::*;

   class digest_scoreboard;
      logic [31:0] state_h [8];
      logic [7:0]  buf_bytes [64];
      int          fill;
      logic [63:0] msg_bits;
      rsp_type     pending [$];
      int          errors;
      int          words_checked;
      int          messages;

      function new();
         errors = 0;
         words_checked = 0;
         messages = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) state_h[i] = StartHash[i];
         fill = 0;
         msg_bits = '0;
      endfunction

      function logic [31:0] rot(input logic [31:0] x, input int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, g, h, wr, s0, s1, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
         a = state_h[0]; b = state_h[1]; c = state_h[2]; d = state_h[3];
         e = state_h[4]; f = state_h[5]; g = state_h[6]; h = state_h[7];
         for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
               wr = w[r];
            end else begin
               s0 = rot(w[(r-15)&15], 7) ^ rot(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
               s1 = rot(w[(r-2)&15], 17) ^ rot(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
               wr = w[r&15] + s0 + w[(r-7)&15] + s1;
               w[r&15] = wr;
            end
            s1 = rot(e, 6) ^ rot(e, 11) ^ rot(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + RoundK[r] + wr;
            s0 = rot(a, 2) ^ rot(a, 13) ^ rot(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         state_h[0] += a; state_h[1] += b; state_h[2] += c; state_h[3] += d;
         state_h[4] += e; state_h[5] += f; state_h[6] += g; state_h[7] += h;
      endfunction

      function void note_item(input req_type it);
         rsp_type r;
         logic [63:0] len;
         if (it.byte_present) begin
            buf_bytes[fill] = it.data_byte;
            fill++;
            msg_bits += 64'd8;
            if (fill == 64) begin
               compress();
               fill = 0;
            end
         end
         if (!it.end_of_message) return;
         buf_bytes[fill] = PadByte;
         fill++;
         if (fill > 56) begin
            while (fill < 64) buf_bytes[fill++] = 8'h00;
            compress();
            fill = 0;
         end
         while (fill < 56) buf_bytes[fill++] = 8'h00;
         len = msg_bits;
         for (int i = 0; i < 8; i++) buf_bytes[63-i] = len[8*i +: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = state_h[i];
            r.word_index = i[2:0];
            r.last_word = (i == 7);
            pending.push_back(r);
         end
         messages++;
         restart();
      endfunction

      function void check_word(input rsp_type got);
         rsp_type exp_w;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected digest word %h", got);
            return;
         end
         exp_w = pending.pop_front();
         words_checked++;
         if (got !== exp_w) begin
            errors++;
            if (errors <= 10)
               $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                        exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                        got.digest_word, got.word_index, got.last_word);
         end
      endfunction
   endclass

   localparam int WatchdogLimit = 20000;
   localparam int ItemCount     = 260;

   logic clock = 1'b0;
   logic reset = 1'b1;
   sha_req_if req ();
   sha_rsp_if rsp ();
   digest_scoreboard sb = new();
   int idle_cycles = 0;
   int items_sent = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sha256_stream_hash_unit i_dut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
   end

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sends one item, with a random gap before it
   task automatic send_item(input logic [7:0] b, input logic pres, input logic eom);
      req_type it;
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      it.data_byte = b;
      it.byte_present = pres;
      it.end_of_message = eom;
      req.valid <= 1'b1;
      req.payload <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_item(it);
      items_sent++;
   endtask

   task automatic send_message(input int len, input int mode);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         b = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
         if ($urandom_range(0, 9) == 0 && i != len - 1) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(b, 1'b1, (i == len - 1) && mode != 3);
      end
      if (len == 0 || mode == 3) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
         if (rsp.valid && rsp.ready) sb.check_word(rsp.payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired");
            $display("sha256_stream_hash_unit test failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty, single byte, padding boundaries, full block, end with no byte
      send_message(0, 0);
      send_message(1, 1);
      send_message(1, 2);
      send_message(55, 0);
      send_message(56, 1);
      send_message(64, 2);
      send_message(2, 3);
      send_message(0, 0);
      while (items_sent < ItemCount) begin
         case ($urandom_range(0, 5))
            0: send_item(8'($urandom), 1'b0, 1'b0);
            default: send_message($urandom_range(0, 20), $urandom_range(0, 3));
         endcase
      end
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d items in %0d messages, including empty and boundary lengths",
               items_sent, sb.messages);
      $display("checked %0d digest words, %0d errors", sb.words_checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("sha256_stream_hash_unit test passed");
      else
         $display("sha256_stream_hash_unit test failed");
      $finish;
   end
endmodule

// File: sha256_stream_hash_unit.f
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_back.sv
sv/sha256_stream_hash_unit.sv
dv/sha256_stream_hash_unit_test.sv
